// ===== rtl/core/qalu_pkg.sv =====
// quaternion alu shared types, constants and tables
`timescale 1ns / 1ps

package qalu_pkg;

   // component format
   localparam int COMPONENT_WIDTH = 16;
   localparam int FRAC_BITS       = 12;
   localparam int CORDIC_STEPS    = 14;

   localparam int CW       = COMPONENT_WIDTH;
   localparam int PROD_W   = 2 * CW;
   localparam int SUM_W    = PROD_W + 2;
   localparam int NUM_LANE = 4;

   // cordic datapath in q6.30 held in a 36 bit word
   localparam int MAX_STEPS = 30;
   localparam int NUM_STEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
   localparam int QW        = 36;
   localparam int ANG_SHIFT = 29 - FRAC_BITS;
   localparam int OUT_SHIFT = 30 - FRAC_BITS;

   localparam logic signed [QW-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [QW-1:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [QW-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [QW-1:0] Q30_KINV    = 36'sd652032874;

   localparam logic signed [QW-1:0] ATAN_TABLE [MAX_STEPS] = '{
      36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159, 36'sd67021687,
      36'sd33543516,  36'sd16775851,  36'sd8388437,   36'sd4194283,   36'sd2097149,
      36'sd1048576,   36'sd524288,    36'sd262144,    36'sd131072,    36'sd65536,
      36'sd32768,     36'sd16384,     36'sd8192,      36'sd4096,      36'sd2048,
      36'sd1024,      36'sd512,       36'sd256,       36'sd128,       36'sd64,
      36'sd32,        36'sd16,        36'sd8,         36'sd4,         36'sd2
   };

   // cordic latency: range reduce, fold, steps, round
   localparam int CORDIC_LAT = NUM_STEPS + 3;
   localparam int LANE_LAT   = 2;

   localparam logic signed [CW-1:0] COMP_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COMP_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] COMP_ONE = CW'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      OP_ADD        = 3'd0,
      OP_SUB        = 3'd1,
      OP_HAMILTON   = 3'd2,
      OP_CONJ       = 3'd3,
      OP_SCALE      = 3'd4,
      OP_AXIS_ANGLE = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      AXIS_X   = 2'd0,
      AXIS_Y   = 2'd1,
      AXIS_Z   = 2'd2,
      AXIS_BAD = 2'd3
   } axis_type;

   typedef enum logic [2:0] {
      LANE_SUM,
      LANE_ADD,
      LANE_SUB,
      LANE_NEG,
      LANE_PASS,
      LANE_ZERO
   } lane_mode_type;

   typedef struct packed {
      lane_mode_type                  mode;
      logic [NUM_LANE-1:0]            neg;
      logic [NUM_LANE-1:0][CW-1:0]    ma;
      logic [NUM_LANE-1:0][CW-1:0]    mb;
      logic [CW-1:0]                  p;
      logic [CW-1:0]                  q;
   } lane_cmd_type;

   typedef struct packed {
      logic [CW-1:0] res_x;
      logic [CW-1:0] res_y;
      logic [CW-1:0] res_z;
      logic [CW-1:0] res_w;
      logic          bad_axis;
      logic          saturated;
   } result_type;

endpackage

// ===== rtl/core/qalu_lane.sv =====
// one component lane: four products, sum, round and saturate, or a direct add, sub, negate or pass
`timescale 1ns / 1ps

module qalu_lane
   import qalu_pkg::*;
(
   input  logic          clock,
   input  lane_cmd_type  cmd,
   output logic [CW-1:0] res,
   output logic          sat
);

   logic signed [PROD_W-1:0] prod_ff [NUM_LANE];
   logic [NUM_LANE-1:0]      neg_ff;
   lane_mode_type            mode_ff;
   logic signed [CW:0]       direct_in, direct_ff;
   logic signed [SUM_W-1:0]  sum, rnd, value;
   logic [CW-1:0]            res_in, res_ff;
   logic                     sat_in, sat_ff;

   always_comb begin
      case (cmd.mode)
         LANE_ADD:  direct_in = $signed({cmd.p[CW-1], cmd.p}) + $signed({cmd.q[CW-1], cmd.q});
         LANE_SUB:  direct_in = $signed({cmd.p[CW-1], cmd.p}) - $signed({cmd.q[CW-1], cmd.q});
         LANE_NEG:  direct_in = -$signed({cmd.p[CW-1], cmd.p});
         LANE_PASS: direct_in = $signed({cmd.p[CW-1], cmd.p});
         default:   direct_in = '0;
      endcase
   end

   // stage one: products
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_LANE; k++) begin
         prod_ff[k] <= $signed(cmd.ma[k]) * $signed(cmd.mb[k]);
      end
      neg_ff    <= cmd.neg;
      mode_ff   <= cmd.mode;
      direct_ff <= direct_in;
   end

   // stage two: exact sum, round half up, pick the direct result in other modes, saturate
   always_comb begin
      sum = '0;
      for (int k = 0; k < NUM_LANE; k++) begin
         if (neg_ff[k]) begin
            sum = sum - SUM_W'(prod_ff[k]);
         end else begin
            sum = sum + SUM_W'(prod_ff[k]);
         end
      end
      rnd = (sum + SUM_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (mode_ff == LANE_SUM) begin
         value = rnd;
      end else begin
         value = SUM_W'(direct_ff);
      end
      sat_in = 1'b0;
      if (value > SUM_W'(COMP_MAX)) begin
         res_in = COMP_MAX;
         sat_in = 1'b1;
      end else if (value < SUM_W'(COMP_MIN)) begin
         res_in = COMP_MIN;
         sat_in = 1'b1;
      end else begin
         res_in = value[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      sat_ff <= sat_in;
   end

   assign res = res_ff;
   assign sat = sat_ff;

endmodule

// ===== rtl/core/qalu_cordic.sv =====
// pipelined cordic giving cos and sin of half the angle
`timescale 1ns / 1ps

module qalu_cordic
   import qalu_pkg::*;
(
   input  logic          clock,
   input  logic [CW-1:0] angle,
   output logic [CW-1:0] cos_out,
   output logic [CW-1:0] sin_out,
   output logic          sat
);

   logic signed [QW-1:0] t_full, t_red_in, t_red_ff;
   logic signed [QW-1:0] t_fold_in;
   logic                 flip_in;

   logic signed [QW-1:0] x_ff [NUM_STEPS+1];
   logic signed [QW-1:0] y_ff [NUM_STEPS+1];
   logic signed [QW-1:0] t_ff [NUM_STEPS+1];
   logic                 f_ff [NUM_STEPS+1];

   // half angle in q30 and reduction into (-pi, pi]
   always_comb begin
      t_full = QW'($signed(angle)) <<< ANG_SHIFT;
      if (t_full <= -Q30_PI) begin
         t_red_in = t_full + Q30_TWO_PI;
      end else if (t_full > Q30_PI) begin
         t_red_in = t_full - Q30_TWO_PI;
      end else begin
         t_red_in = t_full;
      end
   end

   always_ff @(posedge clock) begin
      t_red_ff <= t_red_in;
   end

   // fold outside +-pi/2 by pi and negate at the end
   always_comb begin
      flip_in = 1'b1;
      if (t_red_ff > Q30_HALF_PI) begin
         t_fold_in = t_red_ff - Q30_PI;
      end else if (t_red_ff < -Q30_HALF_PI) begin
         t_fold_in = t_red_ff + Q30_PI;
      end else begin
         t_fold_in = t_red_ff;
         flip_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= Q30_KINV;
      y_ff[0] <= '0;
      t_ff[0] <= t_fold_in;
      f_ff[0] <= flip_in;
   end

   for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (t_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            t_ff[i+1] <= t_ff[i] - ATAN_TABLE[i];
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            t_ff[i+1] <= t_ff[i] + ATAN_TABLE[i];
         end
         f_ff[i+1] <= f_ff[i];
      end
   end

   logic signed [QW-1:0] xo, yo, xr, yr;
   logic [CW-1:0]        cos_in, sin_in, cos_ff, sin_ff;
   logic                 sc, ss, sat_ff;

   always_comb begin
      xo = f_ff[NUM_STEPS] ? -x_ff[NUM_STEPS] : x_ff[NUM_STEPS];
      yo = f_ff[NUM_STEPS] ? -y_ff[NUM_STEPS] : y_ff[NUM_STEPS];
      xr = (xo + QW'(1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      yr = (yo + QW'(1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      sc = 1'b1;
      ss = 1'b1;
      if (xr > QW'(COMP_MAX)) begin
         cos_in = COMP_MAX;
      end else if (xr < QW'(COMP_MIN)) begin
         cos_in = COMP_MIN;
      end else begin
         cos_in = xr[CW-1:0];
         sc     = 1'b0;
      end
      if (yr > QW'(COMP_MAX)) begin
         sin_in = COMP_MAX;
      end else if (yr < QW'(COMP_MIN)) begin
         sin_in = COMP_MIN;
      end else begin
         sin_in = yr[CW-1:0];
         ss     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
      sat_ff <= sc | ss;
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
   assign sat     = sat_ff;

endmodule

// ===== rtl/core/qalu_fifo.sv =====
// result queue holding finished items until the receiver takes them
`timescale 1ns / 1ps

module qalu_fifo
   import qalu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  result_type wr_data,
   input  logic       rd_en,
   output logic       rd_valid,
   output result_type rd_data
);

   localparam int DEPTH = CORDIC_LAT + 3;
   localparam int PW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);

   result_type       mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  fill_ff, fill_in;
   logic             do_rd;

   assign do_rd = rd_en && (fill_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({wr_en, do_rd})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_valid = (fill_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];

endmodule

// ===== rtl/core/quaternion_alu.sv =====
// quaternion alu top level: input stage, lanes, cordic, merge and result queue
`timescale 1ns / 1ps

// quaternion arithmetic unit in signed q4.12
//
// req channel: one request per beat; tdata holds a_x, a_y, a_z, a_w, b_x, b_y,
// b_z, b_w, scale_or_angle (16 bits each, lowest first); tuser holds opcode
// (bits 2:0) and axis_sel (bits 4:3)
// rsp channel: one result per request, in order; tdata holds res_x, res_y,
// res_z, res_w; tuser holds bad_axis (bit 0) and saturated (bit 1)
//
// four component lanes multiply, sum and saturate in parallel while a fully
// unrolled cordic pipeline forms cos/sin of the half angle; a merge stage
// picks the lane results or the rotation quaternion per opcode
//
// the cordic pipeline length sets the delay from request to result; throughput one
// request per cycle while credits remain
// a credit counter admits a request only while the result queue has room,
// so a stalled receiver never loses results; upstream keeps flowing until all
// credits are in use, then req_tready drops
// reset empties the queue and the pipeline; the data registers keep their contents

module quaternion_alu
   import qalu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [143:0]   req_tdata,   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_or_angle
   input  logic [4:0]     req_tuser,   // opcode, axis_sel
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [63:0]    rsp_tdata,   // res_x, res_y, res_z, res_w
   output logic [1:0]     rsp_tuser    // bad_axis, saturated
);

   localparam int CREDITS = CORDIC_LAT + 3;
   localparam int CRW     = $clog2(CREDITS + 1);
   localparam int DLY     = CORDIC_LAT - LANE_LAT;

   typedef struct packed {
      opcode_type op;
      axis_type   axis;
   } ctl_type;

   // request register
   logic                 req_acc;
   logic                 v0_ff;
   logic [CW-1:0]        a_ff [NUM_LANE];   // x, y, z, w
   logic [CW-1:0]        b_ff [NUM_LANE];
   logic [CW-1:0]        s_ff;
   ctl_type              ctl0_ff;

   logic [CRW-1:0]       inflight_ff, inflight_in;
   logic                 rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign req_tready = (inflight_ff < CRW'(CREDITS));

   always_comb begin
      case ({req_acc, rsp_acc})
         2'b10:   inflight_in = inflight_ff + 1'b1;
         2'b01:   inflight_in = inflight_ff - 1'b1;
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         v0_ff       <= 1'b0;
      end else begin
         inflight_ff <= inflight_in;
         v0_ff       <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_LANE; k++) begin
         a_ff[k] <= req_tdata[k*CW +: CW];
         b_ff[k] <= req_tdata[(k+NUM_LANE)*CW +: CW];
      end
      s_ff         <= req_tdata[2*NUM_LANE*CW +: CW];
      ctl0_ff.op   <= opcode_type'(req_tuser[2:0]);
      ctl0_ff.axis <= axis_type'(req_tuser[4:3]);
   end

   // lane commands; index 0 x, 1 y, 2 z, 3 w
   lane_cmd_type cmd [NUM_LANE];

   always_comb begin
      for (int k = 0; k < NUM_LANE; k++) begin
         cmd[k].neg  = '0;
         cmd[k].ma   = '0;
         cmd[k].mb   = '0;
         cmd[k].p    = a_ff[k];
         cmd[k].q    = b_ff[k];
         cmd[k].mode = LANE_ZERO;
      end
      case (ctl0_ff.op)
         OP_ADD: begin
            for (int k = 0; k < NUM_LANE; k++) cmd[k].mode = LANE_ADD;
         end
         OP_SUB: begin
            for (int k = 0; k < NUM_LANE; k++) cmd[k].mode = LANE_SUB;
         end
         OP_CONJ: begin
            for (int k = 0; k < NUM_LANE - 1; k++) cmd[k].mode = LANE_NEG;
            cmd[3].mode = LANE_PASS;
         end
         OP_SCALE: begin
            for (int k = 0; k < NUM_LANE; k++) begin
               cmd[k].mode  = LANE_SUM;
               cmd[k].ma[0] = a_ff[k];
               cmd[k].mb[0] = s_ff;
            end
         end
         OP_HAMILTON: begin
            for (int k = 0; k < NUM_LANE; k++) cmd[k].mode = LANE_SUM;
            // w = aw bw - ax bx - ay by - az bz
            cmd[3].ma  = {a_ff[2], a_ff[1], a_ff[0], a_ff[3]};
            cmd[3].mb  = {b_ff[2], b_ff[1], b_ff[0], b_ff[3]};
            cmd[3].neg = 4'b1110;
            // x = aw bx + ax bw + ay bz - az by
            cmd[0].ma  = {a_ff[2], a_ff[1], a_ff[0], a_ff[3]};
            cmd[0].mb  = {b_ff[1], b_ff[2], b_ff[3], b_ff[0]};
            cmd[0].neg = 4'b1000;
            // y = aw by + ay bw + az bx - ax bz
            cmd[1].ma  = {a_ff[0], a_ff[2], a_ff[1], a_ff[3]};
            cmd[1].mb  = {b_ff[2], b_ff[0], b_ff[3], b_ff[1]};
            cmd[1].neg = 4'b1000;
            // z = aw bz + az bw + ax by - ay bx
            cmd[2].ma  = {a_ff[1], a_ff[0], a_ff[2], a_ff[3]};
            cmd[2].mb  = {b_ff[0], b_ff[1], b_ff[3], b_ff[2]};
            cmd[2].neg = 4'b1000;
         end
         default: begin
            for (int k = 0; k < NUM_LANE; k++) cmd[k].mode = LANE_ZERO;
         end
      endcase
   end

   logic [CW-1:0] lane_res [NUM_LANE];
   logic          lane_sat [NUM_LANE];

   for (genvar g = 0; g < NUM_LANE; g++) begin : g_lane
      qalu_lane u_lane (
         .clock (clock),
         .cmd   (cmd[g]),
         .res   (lane_res[g]),
         .sat   (lane_sat[g])
      );
   end

   logic [CW-1:0] cos_v, sin_v;
   logic          cordic_sat;

   qalu_cordic u_cordic (
      .clock   (clock),
      .angle   (s_ff),
      .cos_out (cos_v),
      .sin_out (sin_v),
      .sat     (cordic_sat)
   );

   // align lane results and control with the cordic output
   logic [NUM_LANE-1:0][CW-1:0] ldly_ff [DLY];
   logic [NUM_LANE-1:0]         lsat_ff [DLY];
   ctl_type                     ctl_ff  [CORDIC_LAT];
   logic [CORDIC_LAT-1:0]       vld_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_LANE; k++) begin
         ldly_ff[0][k] <= lane_res[k];
         lsat_ff[0][k] <= lane_sat[k];
      end
      for (int d = 1; d < DLY; d++) begin
         ldly_ff[d] <= ldly_ff[d-1];
         lsat_ff[d] <= lsat_ff[d-1];
      end
      ctl_ff[0] <= ctl0_ff;
      for (int d = 1; d < CORDIC_LAT; d++) begin
         ctl_ff[d] <= ctl_ff[d-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[CORDIC_LAT-2:0], v0_ff};
      end
   end

   // merge stage
   ctl_type                     ctl_m;
   logic [NUM_LANE-1:0][CW-1:0] lres_m;
   logic [NUM_LANE-1:0]         lsat_m;
   result_type                  merged;

   assign ctl_m  = ctl_ff[CORDIC_LAT-1];
   assign lres_m = ldly_ff[DLY-1];
   assign lsat_m = lsat_ff[DLY-1];

   always_comb begin
      merged.res_x     = lres_m[0];
      merged.res_y     = lres_m[1];
      merged.res_z     = lres_m[2];
      merged.res_w     = lres_m[3];
      merged.bad_axis  = 1'b0;
      merged.saturated = |lsat_m;
      if (ctl_m.op == OP_AXIS_ANGLE) begin
         merged.res_x = '0;
         merged.res_y = '0;
         merged.res_z = '0;
         case (ctl_m.axis)
            AXIS_X: begin
               merged.res_x     = sin_v;
               merged.res_w     = cos_v;
               merged.saturated = cordic_sat;
            end
            AXIS_Y: begin
               merged.res_y     = sin_v;
               merged.res_w     = cos_v;
               merged.saturated = cordic_sat;
            end
            AXIS_Z: begin
               merged.res_z     = sin_v;
               merged.res_w     = cos_v;
               merged.saturated = cordic_sat;
            end
            default: begin
               // invalid axis gives the identity
               merged.res_w     = COMP_ONE;
               merged.bad_axis  = 1'b1;
               merged.saturated = 1'b0;
            end
         endcase
      end
   end

   result_type out_data;

   qalu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (vld_ff[CORDIC_LAT-1]),
      .wr_data  (merged),
      .rd_en    (rsp_tready),
      .rd_valid (rsp_tvalid),
      .rd_data  (out_data)
   );

   assign rsp_tdata = {out_data.res_w, out_data.res_z, out_data.res_y, out_data.res_x};
   assign rsp_tuser = {out_data.saturated, out_data.bad_axis};

   // credits never overrun the queue
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CRW'(CREDITS))
      else $error("request credit count overran");

   // a result on the output always belongs to an admitted request
   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != '0)
      else $error("result without outstanding request");

   // identity for a bad axis is never flagged as clipped
   a_bad_not_sat: assert property (@(posedge clock) disable iff (reset)
      vld_ff[CORDIC_LAT-1] && merged.bad_axis |-> !merged.saturated)
      else $error("bad axis result flagged saturated");

   // merged items come only from accepted requests
   a_merge_from_req: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> $past(v0_ff))
      else $error("pipeline valid without request");

endmodule

// ===== test/tb_quaternion_alu.sv =====
// self-checking testbench for the quaternion alu: scoreboard class and stream drivers
`timescale 1ns / 1ps

module tb_quaternion_alu;
   import qalu_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 550;

   // fixed point helpers for the predictor
   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [15:0] clip16(longint v, ref bit flag);
      if (v > 32767) begin
         flag = 1;
         return 16'sh7fff;
      end
      if (v < -32768) begin
         flag = 1;
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // rounded product sum, half up
   function automatic longint round_sum(longint p0, longint p1, longint p2, longint p3);
      return fshift(p0 + p1 + p2 + p3 + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
   endfunction

   function automatic longint q30_round(longint v);
      return fshift(v + (64'sd1 <<< (OUT_SHIFT - 1)), OUT_SHIFT);
   endfunction

   typedef struct {
      logic [2:0]  op;
      logic [15:0] a [4];
      logic [15:0] b [4];
      logic [15:0] s;
      logic [1:0]  axis;
   } quat_req_type;

   // expected quaternion result for one request
   function automatic result_type predict_quat(quat_req_type rq);
      result_type res;
      longint a [4], b [4], s, t, x, y, nx, dx, dy;
      longint atan [30];
      bit satf, flip;
      logic [15:0] o [4];
      satf = 0;
      flip = 0;
      for (int i = 0; i < 30; i++) atan[i] = ATAN_TABLE[i];
      for (int i = 0; i < 4; i++) begin
         a[i] = longint'($signed(rq.a[i]));
         b[i] = longint'($signed(rq.b[i]));
      end
      s = longint'($signed(rq.s));
      for (int i = 0; i < 4; i++) o[i] = '0;
      res.bad_axis = 0;
      case (rq.op)
         OP_ADD, OP_SUB:
            for (int i = 0; i < 4; i++)
               o[i] = clip16(rq.op == OP_ADD ? a[i] + b[i] : a[i] - b[i], satf);
         OP_HAMILTON: begin
            o[3] = clip16(round_sum(a[3]*b[3], -a[0]*b[0], -a[1]*b[1], -a[2]*b[2]), satf);
            o[0] = clip16(round_sum(a[3]*b[0], a[0]*b[3], a[1]*b[2], -a[2]*b[1]), satf);
            o[1] = clip16(round_sum(a[3]*b[1], a[1]*b[3], a[2]*b[0], -a[0]*b[2]), satf);
            o[2] = clip16(round_sum(a[3]*b[2], a[2]*b[3], a[0]*b[1], -a[1]*b[0]), satf);
         end
         OP_CONJ: begin
            for (int i = 0; i < 3; i++) o[i] = clip16(-a[i], satf);
            o[3] = rq.a[3];
         end
         OP_SCALE:
            for (int i = 0; i < 4; i++) o[i] = clip16(round_sum(a[i]*s, 0, 0, 0), satf);
         OP_AXIS_ANGLE:
            if (rq.axis == AXIS_BAD) begin
               res.bad_axis = 1;
               o[3] = COMP_ONE;
            end else begin
               // half angle in q30, folded into the cordic's convergence range
               t = s * (64'sd1 <<< ANG_SHIFT);
               t = t % longint'(Q30_TWO_PI);
               if (t < 0) t += Q30_TWO_PI;
               if (t > Q30_PI) t -= Q30_TWO_PI;
               if (t > Q30_HALF_PI) begin
                  t -= Q30_PI;
                  flip = 1;
               end else if (t < -longint'(Q30_HALF_PI)) begin
                  t += Q30_PI;
                  flip = 1;
               end
               x = Q30_KINV;
               y = 0;
               for (int i = 0; i < NUM_STEPS; i++) begin
                  dx = fshift(y, i);
                  dy = fshift(x, i);
                  if (t >= 0) begin
                     nx = x - dx; y = y + dy; t -= atan[i];
                  end else begin
                     nx = x + dx; y = y - dy; t += atan[i];
                  end
                  x = nx;
               end
               if (flip) begin
                  x = -x;
                  y = -y;
               end
               o[3] = clip16(q30_round(x), satf);
               o[rq.axis] = clip16(q30_round(y), satf);
            end
         default: ;
      endcase
      res.res_x = o[0];
      res.res_y = o[1];
      res.res_z = o[2];
      res.res_w = o[3];
      res.saturated = satf;
      return res;
   endfunction

   int error_count = 0;

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   class quat_scoreboard;
      result_type pending [$];

      function void note_request(quat_req_type rq);
         pending.push_back(predict_quat(rq));
      endfunction

      task check_result(logic [63:0] data, logic [1:0] user);
         result_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result", data, 0);
            return;
         end
         want = pending.pop_front();
         if (data[15:0] !== want.res_x) report_mismatch("res_x", data[15:0], want.res_x);
         if (data[31:16] !== want.res_y) report_mismatch("res_y", data[31:16], want.res_y);
         if (data[47:32] !== want.res_z) report_mismatch("res_z", data[47:32], want.res_z);
         if (data[63:48] !== want.res_w) report_mismatch("res_w", data[63:48], want.res_w);
         if (user[0] !== want.bad_axis) report_mismatch("bad_axis", user[0], want.bad_axis);
         if (user[1] !== want.saturated) report_mismatch("saturated", user[1], want.saturated);
      endtask
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic [4:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   quaternion_alu dut (.*);

   always #5 clock = ~clock;

   quat_scoreboard board = new();
   quat_req_type   stim_queue [$];
   bit             quiet_phase = 0;   // no idling on either side
   bit             hold_rsp = 0;      // receiver back-pressure stretch
   int             idle_cycles = 0;

   // directed and random request generation
   function automatic quat_req_type rand_req(bit wide);
      quat_req_type rq;
      rq.op = $urandom_range(0, 7) == 7 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      for (int i = 0; i < 4; i++) begin
         rq.a[i] = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 8192)) - 4096);
         rq.b[i] = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 8192)) - 4096);
      end
      rq.s    = 16'($urandom);
      rq.axis = 2'($urandom_range(0, 3));
      return rq;
   endfunction

   function automatic quat_req_type fill_req(logic [2:0] op, logic [15:0] av, logic [15:0] bv,
                                             logic [15:0] s, logic [1:0] axis);
      quat_req_type rq;
      rq.op = op;
      for (int i = 0; i < 4; i++) begin
         rq.a[i] = av;
         rq.b[i] = bv;
      end
      rq.s = s;
      rq.axis = axis;
      return rq;
   endfunction

   task automatic build_stimulus();
      // extremes: saturation on every lane op, conjugate of the most negative value
      stim_queue.push_back(fill_req(OP_ADD, 16'h7fff, 16'h7fff, 0, AXIS_X));
      stim_queue.push_back(fill_req(OP_ADD, 16'h8000, 16'h8000, 0, AXIS_X));
      stim_queue.push_back(fill_req(OP_SUB, 16'h7fff, 16'h8000, 0, AXIS_X));
      stim_queue.push_back(fill_req(OP_SUB, 16'h8000, 16'h7fff, 0, AXIS_X));
      stim_queue.push_back(fill_req(OP_HAMILTON, 16'h8000, 16'h8000, 0, AXIS_X));
      stim_queue.push_back(fill_req(OP_HAMILTON, 16'h7fff, 16'h8000, 0, AXIS_X));
      stim_queue.push_back(fill_req(OP_HAMILTON, 16'h1000, 16'h0800, 0, AXIS_X));
      stim_queue.push_back(fill_req(OP_CONJ, 16'h8000, 0, 0, AXIS_X));
      stim_queue.push_back(fill_req(OP_CONJ, 16'h7fff, 0, 0, AXIS_X));
      stim_queue.push_back(fill_req(OP_SCALE, 16'h8000, 0, 16'h8000, AXIS_X));
      stim_queue.push_back(fill_req(OP_SCALE, 16'h7fff, 0, 16'h0001, AXIS_X));
      stim_queue.push_back(fill_req(OP_SCALE, 16'h0001, 0, 16'h0800, AXIS_X));
      // rotation: zero, +-pi, extremes of the angle, each axis, invalid axis
      stim_queue.push_back(fill_req(OP_AXIS_ANGLE, 0, 0, 16'h0000, AXIS_X));
      stim_queue.push_back(fill_req(OP_AXIS_ANGLE, 0, 0, 16'h3244, AXIS_Y));
      stim_queue.push_back(fill_req(OP_AXIS_ANGLE, 0, 0, 16'hcdbc, AXIS_Z));
      stim_queue.push_back(fill_req(OP_AXIS_ANGLE, 0, 0, 16'h7fff, AXIS_X));
      stim_queue.push_back(fill_req(OP_AXIS_ANGLE, 0, 0, 16'h8000, AXIS_Y));
      stim_queue.push_back(fill_req(OP_AXIS_ANGLE, 0, 0, 16'h1922, AXIS_Z));
      stim_queue.push_back(fill_req(OP_AXIS_ANGLE, 16'h7fff, 0, 16'h1000, AXIS_BAD));
      // unused opcodes
      stim_queue.push_back(fill_req(3'd6, 16'h1234, 16'h4321, 16'h1000, AXIS_BAD));
      stim_queue.push_back(fill_req(3'd7, 16'hffff, 16'hffff, 16'hffff, AXIS_BAD));
      for (int n = 0; n < RANDOM_ITEMS; n++)
         stim_queue.push_back(rand_req($urandom_range(0, 2) != 0));
   endtask

   task automatic send_requests();
      quat_req_type rq;
      while (stim_queue.size() > 0) begin
         @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 99) < 14) begin
            req_tvalid <= 0;
         end else begin
            rq = stim_queue.pop_front();
            req_tvalid <= 1;
            req_tdata  <= {rq.s, rq.b[3], rq.b[2], rq.b[1], rq.b[0],
                           rq.a[3], rq.a[2], rq.a[1], rq.a[0]};
            req_tuser  <= {rq.axis, rq.op};
            // hold until accepted
            do @(posedge clock); while (!req_tready);
            board.note_request(rq);
         end
      end
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset || hold_rsp)
         rsp_tready <= 0;
      else
         rsp_tready <= quiet_phase || ($urandom_range(0, 99) >= 14);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // long back-pressure stretch early in the random part
   initial begin
      wait (!reset);
      repeat (60) @(posedge clock);
      hold_rsp = 1;
      repeat (200) @(posedge clock);
      hold_rsp = 0;
      // later a stretch with no idling
      repeat (100) @(posedge clock);
      quiet_phase = 1;
      repeat (400) @(posedge clock);
      quiet_phase = 0;
   end

   initial begin
      build_stimulus();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_requests();
      wait (board.pending.size() == 0);
      repeat (CORDIC_LAT + 10) @(posedge clock);
      if (error_count == 0 && board.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
